[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[src/magma_pkg.sv]
// ----------------------------------------------------------------------------
// Magma cipher package
// Shared types, S-box table, round function and subkey schedule.
// ----------------------------------------------------------------------------
`default_nettype none

package magma_pkg;

    localparam int unsigned NUM_ROUNDS = 32;
    localparam int unsigned LATENCY    = NUM_ROUNDS;
    localparam int unsigned NUM_KEYS   = 8;

    // Table 0 serves the most significant nibble.
    localparam logic [3:0] SBOX [0:7][0:15] = '{
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
    };

    typedef struct packed {
        logic valid;
        logic decrypt;
    } ctrl_t;

    // Key addition, nibble substitution and rotate left by 11.
    function automatic logic [31:0] round_fn(input logic [31:0] half,
                                             input logic [31:0] subkey);
        logic [31:0] s;
        logic [31:0] t;
        s = half + subkey;
        for (int n = 0; n < 8; n++)
        begin
            t[4*n +: 4] = SBOX[7-n][s[4*n +: 4]];
        end
        return {t[20:0], t[31:21]};
    endfunction

    function automatic logic [2:0] enc_sel(input int unsigned r);
        return (r < 24) ? r[2:0] : 3'(31 - r);
    endfunction

    function automatic logic [2:0] dec_sel(input int unsigned r);
        return (r < 8) ? r[2:0] : 3'(7 - (r % 8));
    endfunction

endpackage

`default_nettype wire

[src/magma_round.sv]
// ----------------------------------------------------------------------------
// Magma round stage
// One Feistel round followed by the stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module magma_round (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire magma_pkg::ctrl_t  ctrl_in,
    input  wire logic [31:0]       left_in,
    input  wire logic [31:0]       right_in,
    input  wire logic [31:0]       subkey,
    output magma_pkg::ctrl_t       ctrl_out,
    output logic [31:0]            left_out,
    output logic [31:0]            right_out
);

    magma_pkg::ctrl_t ctrl_reg;
    logic [31:0]      left_reg;
    logic [31:0]      right_reg;
    logic [31:0]      right_next;

    assign right_next = left_in ^ magma_pkg::round_fn(right_in, subkey);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    // Data only moves with a valid transfer; it needs no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl_in.valid)
        begin
            left_reg  <= right_in;
            right_reg <= right_next;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign left_out  = left_reg;
    assign right_out = right_reg;

endmodule

`default_nettype wire

[src/magma_block_cipher_core.sv]
// The done strobe follows the start transfer through the round pipeline, one round per stage.
// Throughput: one block per cycle; busy stays low and a block may start every cycle.
// The 32-stage round pipeline sets the latency and the throughput; results cannot be stalled.
// Reset clears the key registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// Magma block cipher core
// Fully pipelined 64-bit encrypt/decrypt engine with a 256-bit key written as eight 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

module magma_block_cipher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [3:0]  wr_index,
    input  wire logic [31:0] wr_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cmd,
    input  wire logic [63:0] block_in,
    output logic             done,
    output logic [63:0]      block_out
);

    localparam int unsigned NR = magma_pkg::NUM_ROUNDS;

    logic [31:0]      key_reg [0:magma_pkg::NUM_KEYS-1];
    magma_pkg::ctrl_t ctrl  [0:NR];
    logic [31:0]      lh    [0:NR];
    logic [31:0]      rh    [0:NR];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < magma_pkg::NUM_KEYS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (wr_en && !wr_index[3])
        begin
            key_reg[wr_index[2:0]] <= wr_data;
        end
    end

    assign busy          = 1'b0;
    assign ctrl[0].valid   = start && !busy;
    assign ctrl[0].decrypt = cmd;
    assign lh[0]         = block_in[63:32];
    assign rh[0]         = block_in[31:0];

    for (genvar r = 0; r < NR; r++)
    begin : g_round
        localparam logic [2:0] ENC_SEL = magma_pkg::enc_sel(r);
        localparam logic [2:0] DEC_SEL = magma_pkg::dec_sel(r);
        logic [31:0] subkey;

        assign subkey = ctrl[r].decrypt ? key_reg[DEC_SEL] : key_reg[ENC_SEL];

        magma_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl_in   (ctrl[r]),
            .left_in   (lh[r]),
            .right_in  (rh[r]),
            .subkey    (subkey),
            .ctrl_out  (ctrl[r+1]),
            .left_out  (lh[r+1]),
            .right_out (rh[r+1])
        );
    end

    // The last round does not swap, so the final stage's halves are undone here.
    assign done      = ctrl[NR].valid;
    assign block_out = {rh[NR], lh[NR]};

endmodule

`default_nettype wire

[src/magma_checker.sv]
// ----------------------------------------------------------------------------
// Magma core port checker
// Checks that busy stays low and the start/done timing seen on the ports of the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module magma_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    `ASSERT_NEVER(a_never_busy, clk, rst_n, busy, "core refused a block")
    `ASSERT_IMPLY(a_done_has_start, clk, rst_n, done, $past(start && !busy, magma_pkg::LATENCY), "done without a matching start")
    `ASSERT_IMPLY(a_start_gives_done, clk, rst_n, $past(start && !busy, magma_pkg::LATENCY) && $past(rst_n, magma_pkg::LATENCY), done, "start transfer lost")
    `ASSERT_IMPLY(a_quiet_after_reset, clk, rst_n, $rose(rst_n), !done, "done right after reset")

endmodule

bind magma_block_cipher_core magma_checker u_magma_checker (.*);

`default_nettype wire

[dv/tb_magma_block_cipher_core.sv]
// ----------------------------------------------------------------------------
// Magma block cipher core testbench
// Sends encrypt and decrypt commands under several keys and sender idle
// rates, predicts every output block with a local cipher model and compares
// each done strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_magma_block_cipher_core;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned RANDOM_PER_KEY = 205;
    localparam int unsigned NUM_INDEXES    = 16;
    localparam logic [63:0] ALL_ONES_64    = 64'hffff_ffff_ffff_ffff;
    localparam logic [31:0] ALL_ONES_32    = 32'hffff_ffff;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } cipher_op_e;

    // Substitution tables, table 0 serving the most significant nibble.
    localparam logic [3:0] SUBST [0:7][0:15] = '{
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
    };

    typedef struct {
        cipher_op_e  op;
        logic [63:0] block_in;
        logic [63:0] block_out;
    } block_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        wr_en;
    logic [3:0]  wr_index;
    logic [31:0] wr_data;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [63:0] block_in;
    logic        done;
    logic [63:0] block_out;

    logic [31:0]   key_words [magma_pkg::NUM_KEYS];
    block_result_t expected_blocks [$];
    int unsigned   mismatch_count = 0;
    int unsigned   idle_cycles    = 0;
    int unsigned   idle_pct       = 0;

    magma_block_cipher_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .block_in  (block_in),
        .done      (done),
        .block_out (block_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] mix_half(input logic [31:0] half,
                                             input logic [31:0] subkey);
        logic [31:0] sum;
        logic [31:0] subst;
        sum = half + subkey;
        for (int n = 0; n < 8; n++)
        begin
            subst[28 - 4*n +: 4] = SUBST[n][sum[28 - 4*n +: 4]];
        end
        return {subst[20:0], subst[31:21]};
    endfunction

    function automatic logic [2:0] key_slot(input int unsigned r, input logic decrypt);
        if (!decrypt)
            return (r < 24) ? 3'(r % 8) : 3'(31 - r);
        return (r < 8) ? 3'(r) : 3'(7 - (r % 8));
    endfunction

    function automatic logic [63:0] magma_transform(input logic decrypt,
                                                    input logic [63:0] blk);
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] mixed;
        left  = blk[63:32];
        right = blk[31:0];
        for (int r = 0; r < 31; r++)
        begin
            mixed = left ^ mix_half(right, key_words[key_slot(r, decrypt)]);
            left  = right;
            right = mixed;
        end
        // The last round leaves the halves in place.
        left ^= mix_half(right, key_words[key_slot(31, decrypt)]);
        return {left, right};
    endfunction

    function automatic logic [63:0] random_block();
        logic [63:0] one_hot;
        one_hot = 64'd1 << $urandom_range(63);
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_ONES_64;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] random_key_word(input logic extreme);
        if (!extreme)
            return $urandom;
        return $urandom_range(1) ? ALL_ONES_32 : 32'h0;
    endfunction

    // Start stays high when the next transfer follows without a gap.
    // Each cycle after a transfer is idle with the phase's idle percentage.
    task automatic send_block(input cipher_op_e op, input logic [63:0] blk);
        block_result_t item;
        start    <= 1'b1;
        cmd      <= op;
        block_in <= blk;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        item.op        = op;
        item.block_in  = blk;
        item.block_out = magma_transform(op == OP_DECRYPT, blk);
        expected_blocks.push_back(item);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start    <= 1'b0;
            cmd      <= 1'($urandom);
            block_in <= {$urandom, $urandom};
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        if (idx < magma_pkg::NUM_KEYS)
            key_words[idx[2:0]] = data;
    endtask

    task automatic load_key(input logic [255:0] key);
        for (int i = 0; i < magma_pkg::NUM_KEYS; i++)
            write_reg(4'(i), key[255 - 32*i -: 32]);
        wr_en <= 1'b0;
    endtask

    task automatic test_reset_key();
        idle_pct = 0;
        send_block(OP_ENCRYPT, '0);
        send_block(OP_DECRYPT, '0);
        send_block(OP_ENCRYPT, ALL_ONES_64);
        send_block(OP_DECRYPT, ALL_ONES_64);
        send_block(OP_ENCRYPT, 64'h8000_0000_0000_0001);
        send_block(OP_DECRYPT, 64'h8000_0000_0000_0001);
        wait_for_results();
    endtask

    task automatic test_extreme_keys();
        idle_pct = 0;
        load_key(256'hffeeddccbbaa99887766554433221100_f0f1f2f3f4f5f6f7f8f9fafbfcfdfeff);
        send_block(OP_ENCRYPT, 64'hfedc_ba98_7654_3210);
        send_block(OP_DECRYPT, 64'h4ee9_01e5_c2d8_ca3d);
        wait_for_results();
        load_key({8{ALL_ONES_32}});
        send_block(OP_ENCRYPT, '0);
        send_block(OP_DECRYPT, '0);
        send_block(OP_ENCRYPT, ALL_ONES_64);
        send_block(OP_DECRYPT, ALL_ONES_64);
        wait_for_results();
    endtask

    // Writes to indexes past the last key word must leave the key alone.
    task automatic test_ignored_index();
        idle_pct = 0;
        for (int i = magma_pkg::NUM_KEYS; i < NUM_INDEXES; i++)
            write_reg(4'(i), $urandom);
        wr_en <= 1'b0;
        send_block(OP_ENCRYPT, 64'h0123_4567_89ab_cdef);
        send_block(OP_DECRYPT, 64'h0123_4567_89ab_cdef);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int unsigned phase_idle [3] = '{0, 83, 34};
        logic [255:0] key;
        for (int p = 0; p < 3; p++)
        begin
            idle_pct = phase_idle[p];
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < magma_pkg::NUM_KEYS; i++)
                    key[255 - 32*i -: 32] = random_key_word(k == 1);
                load_key(key);
                repeat (RANDOM_PER_KEY)
                    send_block(cipher_op_e'($urandom_range(1)), random_block());
                wait_for_results();
            end
        end
    endtask

    always @(posedge clk)
    begin
        block_result_t item;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h",
                         $time, block_out);
                mismatch_count++;
            end
            else
            begin
                item = expected_blocks.pop_front();
                if (block_out !== item.block_out)
                begin
                    $display("%0t: block_out for %s of %h: expected %h, actual %h",
                             $time, item.op.name(), item.block_in, item.block_out,
                             block_out);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || wr_en || done === 1'b1 || (start && busy === 1'b0))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        start    = 1'b0;
        cmd      = OP_ENCRYPT;
        block_in = '0;
        for (int i = 0; i < magma_pkg::NUM_KEYS; i++)
            key_words[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_extreme_keys();
        test_ignored_index();
        test_random_traffic();

        wait_for_results();
        repeat (magma_pkg::LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0 && expected_blocks.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
